/* rtl/assert_macros.svh */
// Assertion macros for the RTL file that carries concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Same-cycle implication checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/lmsd_pkg.sv */
// Package: sizes, types, codes and frame composition functions of the matrix driver
`timescale 1ns / 1ps

package lmsd_pkg;

	localparam int ROWS        = 7;
	localparam int COLS        = 5;
	localparam int GLYPH_W     = ROWS * COLS;
	localparam int ROW_IW      = $clog2(ROWS);
	localparam int COL_IW      = $clog2(COLS);
	localparam int LIT_W       = 3;
	localparam int BLANK_W     = 4;
	localparam int BLANK_LIMIT = 8;
	localparam int GAP_W       = 3;
	localparam int POS_W       = 4;
	localparam int CFG_IDX_W   = 2;

	typedef logic [GLYPH_W-1:0] glyph_t;
	typedef logic [COLS-1:0]    row_pat_t;   // one row: bit c = column c
	typedef row_pat_t [ROWS-1:0] frame_t;
	typedef logic [ROWS-1:0]    col_pat_t;   // one column: bit r = row r
	typedef col_pat_t [COLS-1:0] col_set_t;
	typedef logic [GAP_W-1:0]   gap_t;
	typedef logic [POS_W-1:0]   pos_t;

	typedef enum logic [1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_SHOW   = 2'd1,
		FUNC_SCROLL = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_RIGHT = 2'd2,
		DIR_LEFT  = 2'd3
	} dir_t;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_LEVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATE    = 2'd2;

	typedef struct packed {
		logic row_level;
		logic col_level;
		logic rotate;
	} cfg_t;

	typedef struct packed {
		func_t  func;
		glyph_t glyph_a;
		glyph_t glyph_b;
		logic   is_space;
		dir_t   dir;
		gap_t   gap;
		pos_t   pos;
	} item_t;

	// Control handed from the input stage to the scan unit
	typedef struct packed {
		logic  advance;
		func_t func;
		logic  is_space;
	} scan_ctl_t;

	// Column bitmaps to row bitmaps, optionally turned through 180 degrees
	function automatic frame_t to_rows(col_set_t cols, logic rot);
		frame_t f;
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLS; c++) begin
				f[r][c] = rot ? cols[COLS-1-c][ROWS-1-r] : cols[c][r];
			end
		end
		return f;
	endfunction

	// Step counted from the far end, for the reversed scroll directions
	function automatic pos_t rev_step(pos_t step, gap_t gap, int size);
		int lim;
		int s;
		lim = size + int'(gap);
		s   = int'(step);
		if (s > lim) begin
			s = lim;
		end
		return POS_W'(lim - s);
	endfunction

	// Horizontal scroll: columns of cur move out, columns of nxt move in
	function automatic frame_t shift_cols(glyph_t cur, glyph_t nxt, gap_t gap, pos_t step,
			logic rot);
		col_set_t gc;
		col_set_t gn;
		col_set_t o;
		int lim;
		int s;
		int base;
		gc   = col_set_t'(cur);
		gn   = col_set_t'(nxt);
		lim  = COLS + int'(gap);
		s    = int'(step);
		if (s > lim) begin
			s = lim;
		end
		base = lim - s;
		for (int p = 0; p < COLS; p++) begin
			if (p >= base) begin
				o[p] = gn[COL_IW'(p - base)];
			end else if (p + s < COLS) begin
				o[p] = gc[COL_IW'(p + s)];
			end else begin
				o[p] = '0;
			end
		end
		return to_rows(o, rot);
	endfunction

	// Vertical scroll: rows of cur move out, rows of nxt move in
	function automatic frame_t shift_rows(glyph_t cur, glyph_t nxt, gap_t gap, pos_t step,
			logic rot);
		frame_t cr;
		frame_t nr;
		frame_t o;
		int lim;
		int s;
		int base;
		cr   = to_rows(col_set_t'(cur), rot);
		nr   = to_rows(col_set_t'(nxt), rot);
		lim  = ROWS + int'(gap);
		s    = int'(step);
		if (s > lim) begin
			s = lim;
		end
		base = lim - s;
		for (int p = 0; p < ROWS; p++) begin
			if (p >= base) begin
				o[p] = nr[ROW_IW'(p - base)];
			end else if (p + s < ROWS) begin
				o[p] = cr[ROW_IW'(p + s)];
			end else begin
				o[p] = '0;
			end
		end
		return o;
	endfunction

endpackage

/* rtl/lmsd_if.sv */
// Channel interfaces: input items and scan results, each with valid/ready
`timescale 1ns / 1ps

interface lmsd_in_if import lmsd_pkg::*; ();
	logic         valid;
	logic         ready;
	logic [1:0]   func;
	glyph_t       glyph_a;
	glyph_t       glyph_b;
	logic         glyph_is_space;
	logic [1:0]   scroll_dir;
	gap_t         gap_lines;
	pos_t         scroll_position;

	modport source (output valid, func, glyph_a, glyph_b, glyph_is_space, scroll_dir,
		gap_lines, scroll_position, input ready);
	modport sink (input valid, func, glyph_a, glyph_b, glyph_is_space, scroll_dir,
		gap_lines, scroll_position, output ready);
endinterface

interface lmsd_out_if import lmsd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ROWS-1:0]  row_levels;
	logic [COLS-1:0]  column_levels;
	logic [LIT_W-1:0] lit_row;
	logic             scan_frozen;

	modport source (output valid, row_levels, column_levels, lit_row, scan_frozen,
		input ready);
	modport sink (input valid, row_levels, column_levels, lit_row, scan_frozen,
		output ready);
endinterface

/* rtl/led_matrix_scan_scroll_driver_core.sv */
// A tick's result passes through the input register and then the result register.
// Throughput: one item per cycle while no tick waits; show and scroll never stall, a tick waits only on a held result.
// The frame store, row counter and freeze counter update when the item moves on from the input register.
// Reset (arst_n, asynchronous, active low): frame dark, row 0, freeze disarmed,
// row lines inactive, column lines dark, registers at row level 0, column level 1, no rotation.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module led_matrix_scan_scroll_driver_core import lmsd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data,
	lmsd_in_if.sink              item,
	lmsd_out_if.source           result
);

	cfg_t      cfg_q;
	item_t     item_s1;
	logic      valid_s1;
	logic      advance;
	logic      out_free;
	frame_t    frame;
	scan_ctl_t scan_ctl;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_level <= 1'b0;
			cfg_q.col_level <= 1'b1;
			cfg_q.rotate    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_LEVEL: cfg_q.row_level <= cfg_data;
				REG_COL_LEVEL: cfg_q.col_level <= cfg_data;
				REG_ROTATE:    cfg_q.rotate    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage: a tick moves on only when the result register is free
	assign advance    = valid_s1 && ((item_s1.func != FUNC_TICK) || out_free);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.func     <= func_t'(item.func);
			item_s1.glyph_a  <= item.glyph_a;
			item_s1.glyph_b  <= item.glyph_b;
			item_s1.is_space <= item.glyph_is_space;
			item_s1.dir      <= dir_t'(item.scroll_dir);
			item_s1.gap      <= item.gap_lines;
			item_s1.pos      <= item.scroll_position;
		end
	end

	assign scan_ctl.advance  = advance;
	assign scan_ctl.func     = item_s1.func;
	assign scan_ctl.is_space = item_s1.is_space;

	lmsd_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.cfg     (cfg_q),
		.frame   (frame)
	);

	lmsd_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.frame    (frame),
		.cfg      (cfg_q),
		.out_free (out_free),
		.result   (result)
	);

	// A tick held behind an untaken result blocks new transfers
	`ASSERT_IMPLIES(a_tick_stall, clk, arst_n,
		valid_s1 && item_s1.func == FUNC_TICK && result.valid && !result.ready, !item.ready)
	// Every accepted item lands in the input register
	`ASSERT_NEXT(a_item_loaded, clk, arst_n, item.valid && item.ready, valid_s1)
	// The reported row is always a real row
	`ASSERT_IMPLIES(a_lit_row_range, clk, arst_n, result.valid,
		result.lit_row <= LIT_W'(ROWS - 1))

endmodule

/* rtl/lmsd_frame.sv */
// Frame store and the show / scroll composition logic
`timescale 1ns / 1ps

module lmsd_frame import lmsd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   advance,
	input  item_t  item_s1,
	input  cfg_t   cfg,
	output frame_t frame
);

	frame_t frame_q;
	frame_t frame_d;
	dir_t   dir_eff;

	// Upside-down mounting swaps up/down and right/left
	assign dir_eff = dir_t'(item_s1.dir ^ {1'b0, cfg.rotate});

	// New frame content for show and scroll
	always_comb begin
		frame_d = frame_q;
		case (item_s1.func)
			FUNC_SHOW: begin
				frame_d = to_rows(col_set_t'(item_s1.glyph_a), cfg.rotate);
			end
			FUNC_SCROLL: begin
				unique case (dir_eff)
					DIR_UP: frame_d = shift_rows(item_s1.glyph_a, item_s1.glyph_b,
						item_s1.gap, item_s1.pos, cfg.rotate);
					DIR_DOWN: frame_d = shift_rows(item_s1.glyph_b, item_s1.glyph_a,
						item_s1.gap, rev_step(item_s1.pos, item_s1.gap, ROWS), cfg.rotate);
					DIR_RIGHT: frame_d = shift_cols(item_s1.glyph_a, item_s1.glyph_b,
						item_s1.gap, item_s1.pos, cfg.rotate);
					DIR_LEFT: frame_d = shift_cols(item_s1.glyph_b, item_s1.glyph_a,
						item_s1.gap, rev_step(item_s1.pos, item_s1.gap, COLS), cfg.rotate);
					default: frame_d = frame_q;
				endcase
			end
			default: frame_d = frame_q;
		endcase
	end

	// Frame store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else if (advance) begin
			frame_q <= frame_d;
		end
	end

	assign frame = frame_q;

endmodule

/* rtl/lmsd_scan.sv */
// Row scan: row counter, blank freeze, line levels and the result register
`timescale 1ns / 1ps

module lmsd_scan import lmsd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  scan_ctl_t        ctl,
	input  frame_t           frame,
	input  cfg_t             cfg,
	output logic             out_free,
	lmsd_out_if.source       result
);

	logic [ROW_IW-1:0]  row_q;
	logic [BLANK_W-1:0] blank_q;
	logic [ROWS-1:0]    last_rows_q;
	logic [COLS-1:0]    last_cols_q;

	logic               res_valid_q;
	logic [ROWS-1:0]    res_rows_q;
	logic [COLS-1:0]    res_cols_q;
	logic [LIT_W-1:0]   res_lit_q;
	logic               res_frozen_q;

	logic               frozen;
	logic [ROW_IW-1:0]  row_next;
	row_pat_t           pat;
	logic [ROWS-1:0]    rows_drv;
	logic [COLS-1:0]    cols_drv;
	logic               tick;

	assign frozen   = (blank_q >= BLANK_W'(BLANK_LIMIT));
	assign tick     = ctl.advance && (ctl.func == FUNC_TICK);
	assign out_free = !res_valid_q || result.ready;

	// Next row with wrap, and the line levels for it
	assign row_next = (row_q == ROW_IW'(ROWS - 1)) ? '0 : row_q + 1'b1;
	assign pat      = frame[row_next];
	assign rows_drv = {ROWS{~cfg.row_level}} ^ (ROWS'(1) << row_next);
	assign cols_drv = cfg.col_level ? pat : ~pat;

	// Scan state and blank freeze counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			blank_q     <= '0;
			last_rows_q <= '1;
			last_cols_q <= '0;
		end else if (ctl.advance) begin
			case (ctl.func)
				FUNC_SHOW: begin
					if (!ctl.is_space) begin
						blank_q <= '0;
					end else if (blank_q == '0) begin
						blank_q <= BLANK_W'(1);
					end
				end
				FUNC_SCROLL: begin
					blank_q <= '0;
				end
				FUNC_TICK: begin
					if (!frozen) begin
						row_q       <= row_next;
						last_rows_q <= rows_drv;
						last_cols_q <= cols_drv;
						if (blank_q != '0 && pat == '0) begin
							blank_q <= blank_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Result register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tick) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register: payload; a frozen tick repeats the last levels
	always_ff @(posedge clk) begin
		if (tick) begin
			if (frozen) begin
				res_rows_q   <= last_rows_q;
				res_cols_q   <= last_cols_q;
				res_lit_q    <= LIT_W'(row_q);
				res_frozen_q <= 1'b1;
			end else begin
				res_rows_q   <= rows_drv;
				res_cols_q   <= cols_drv;
				res_lit_q    <= LIT_W'(row_next);
				res_frozen_q <= 1'b0;
			end
		end
	end

	assign result.valid         = res_valid_q;
	assign result.row_levels    = res_rows_q;
	assign result.column_levels = res_cols_q;
	assign result.lit_row       = res_lit_q;
	assign result.scan_frozen   = res_frozen_q;

endmodule

/* bench/led_matrix_scan_scroll_driver_core_chk.sv */
// Scoreboard for the matrix driver: predicts each tick's scan levels and compares results
`timescale 1ns / 1ps

module led_matrix_scan_scroll_driver_core_chk import lmsd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data,
	lmsd_in_if                   items,
	lmsd_out_if                  results,
	output int                   errors,
	output int                   pending
);

	localparam int MAX_REPORTS = 150;

	// Up to seven lanes of seven dots: glyph columns, or frame rows
	typedef logic [ROWS-1:0][ROWS-1:0] lanes_t;

	typedef struct packed {
		logic [ROWS-1:0]  rows;
		logic [COLS-1:0]  cols;
		logic [LIT_W-1:0] lit;
		logic             frozen;
	} scan_levels_t;

	scan_levels_t              scan_queue[$];
	cfg_t                      regs;
	logic [ROWS-1:0][COLS-1:0] frame;
	logic [LIT_W-1:0]          row_ptr;
	logic [BLANK_W-1:0]        blank_run;
	logic [ROWS-1:0]           held_rows;
	logic [COLS-1:0]           held_cols;
	int                        err_count = 0;

	// Split a glyph into its column bitmaps
	function automatic lanes_t glyph_columns(glyph_t g);
		lanes_t l;
		l = '0;
		for (int c = 0; c < COLS; c++) begin
			l[c] = g[ROWS*c +: ROWS];
		end
		return l;
	endfunction

	// Column bitmaps to row bitmaps, turned through 180 degrees when mounted upside down
	function automatic lanes_t columns_to_rows(lanes_t cols, logic rot);
		lanes_t l;
		l = '0;
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLS; c++) begin
				l[r][c] = rot ? cols[COLS-1-c][ROWS-1-r] : cols[c][r];
			end
		end
		return l;
	endfunction

	// Window of n lanes over cur, a blank gap, then nxt, moved on by step lanes
	function automatic lanes_t slide(lanes_t cur, lanes_t nxt, int n, int gap, int step);
		lanes_t l;
		int     s;
		int     base;
		s    = (step > n + gap) ? n + gap : step;
		base = n + gap - s;
		l    = '0;
		for (int p = 0; p < n; p++) begin
			if (p >= base) begin
				l[p] = nxt[p - base];
			end else if (p + s < n) begin
				l[p] = cur[p + s];
			end
		end
		return l;
	endfunction

	// Step seen from the other end, for downward and leftward scrolls
	function automatic int far_step(int step, int gap, int n);
		return n + gap - ((step > n + gap) ? n + gap : step);
	endfunction

	function automatic lanes_t vertical(glyph_t cur, glyph_t nxt, int gap, int step, logic rot);
		return slide(columns_to_rows(glyph_columns(cur), rot),
			columns_to_rows(glyph_columns(nxt), rot), ROWS, gap, step);
	endfunction

	function automatic lanes_t horizontal(glyph_t cur, glyph_t nxt, int gap, int step,
			logic rot);
		return columns_to_rows(slide(glyph_columns(cur), glyph_columns(nxt), COLS, gap, step),
			rot);
	endfunction

	task automatic load_frame(lanes_t l);
		for (int r = 0; r < ROWS; r++) begin
			frame[r] = l[r][COLS-1:0];
		end
	endtask

	// Update the frame and scan state for one accepted item; ticks queue their levels
	task automatic predict_item();
		scan_levels_t   lv;
		logic [COLS-1:0] pat;
		int             gap;
		int             step;
		gap  = int'(items.gap_lines);
		step = int'(items.scroll_position);
		case (items.func)
			FUNC_SHOW: begin
				load_frame(columns_to_rows(glyph_columns(items.glyph_a), regs.rotate));
				if (items.glyph_is_space) begin
					if (blank_run == '0) begin
						blank_run = BLANK_W'(1);
					end
				end else begin
					blank_run = '0;
				end
			end
			FUNC_SCROLL: begin
				// upside down swaps up with down and right with left
				case (dir_t'(items.scroll_dir ^ {1'b0, regs.rotate}))
					DIR_UP: begin
						load_frame(vertical(items.glyph_a, items.glyph_b, gap, step,
							regs.rotate));
					end
					DIR_DOWN: begin
						load_frame(vertical(items.glyph_b, items.glyph_a, gap,
							far_step(step, gap, ROWS), regs.rotate));
					end
					DIR_RIGHT: begin
						load_frame(horizontal(items.glyph_a, items.glyph_b, gap, step,
							regs.rotate));
					end
					default: begin
						load_frame(horizontal(items.glyph_b, items.glyph_a, gap,
							far_step(step, gap, COLS), regs.rotate));
					end
				endcase
				blank_run = '0;
			end
			FUNC_TICK: begin
				if (blank_run >= BLANK_LIMIT) begin
					// frozen: levels and row held
					lv.frozen = 1'b1;
				end else begin
					row_ptr = (row_ptr == ROWS - 1) ? '0 : row_ptr + 1'b1;
					pat     = frame[row_ptr];
					if (blank_run != '0 && pat == '0) begin
						blank_run = blank_run + 1'b1;
					end
					held_rows = {ROWS{~regs.row_level}} ^ (ROWS'(1) << row_ptr);
					held_cols = regs.col_level ? pat : ~pat;
					lv.frozen = 1'b0;
				end
				lv.rows = held_rows;
				lv.cols = held_cols;
				lv.lit  = row_ptr;
				scan_queue.push_back(lv);
			end
			default: ;
		endcase
	endtask

	task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			err_count++;
			if (err_count <= MAX_REPORTS) begin
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			end
		end
	endtask

	task automatic check_result();
		scan_levels_t lv;
		if (scan_queue.size() == 0) begin
			err_count++;
			if (err_count <= MAX_REPORTS) begin
				$display("%0t: result with none expected, got rows %0h cols %0h row %0d",
					$time, results.row_levels, results.column_levels, results.lit_row);
			end
		end else begin
			lv = scan_queue.pop_front();
			compare_field("row_levels", 8'(lv.rows), 8'(results.row_levels));
			compare_field("column_levels", 8'(lv.cols), 8'(results.column_levels));
			compare_field("lit_row", 8'(lv.lit), 8'(results.lit_row));
			compare_field("scan_frozen", 8'(lv.frozen), 8'(results.scan_frozen));
		end
	endtask

	// Results are checked before the item of the same edge is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.row_level = 1'b0;
			regs.col_level = 1'b1;
			regs.rotate    = 1'b0;
			frame          = '0;
			row_ptr        = '0;
			blank_run      = '0;
			held_rows      = '1;
			held_cols      = '0;
			scan_queue.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROW_LEVEL: regs.row_level = cfg_data;
					REG_COL_LEVEL: regs.col_level = cfg_data;
					REG_ROTATE:    regs.rotate    = cfg_data;
					default: ;
				endcase
			end
			if (results.valid && results.ready) begin
				check_result();
			end
			if (items.valid && items.ready) begin
				predict_item();
			end
		end
		errors  <= err_count;
		pending <= scan_queue.size();
	end

endmodule

/* bench/led_matrix_scan_scroll_driver_core_tb.sv */
// Testbench top: clock, reset, register writes and item stimulus for the matrix driver
`timescale 1ns / 1ps

module led_matrix_scan_scroll_driver_core_tb import lmsd_pkg::*; ();

	localparam logic [1:0]           FUNC_NONE   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;
	localparam int                   IDLE_PCT    = 18;
	localparam int                   STALL_LIMIT = 2000;
	localparam int                   SETTLE      = 6;
	localparam int                   NUM_PHASES  = 8;
	localparam int                   PHASE_ITEMS = 66;
	localparam glyph_t               FULL        = '1;
	localparam glyph_t               CHECKER_A   = 35'h5_5555_5555;
	localparam glyph_t               CHECKER_B   = 35'h2_AAAA_AAAA;
	// row level, column level, rotation for the first phases
	localparam logic [3:0][2:0]      PRESETS     = {3'b000, 3'b110, 3'b011, 3'b101};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic                 cfg_data;
	logic                 calm;
	int                   errors;
	int                   pending;
	int                   stall_cycles = 0;

	lmsd_in_if  in_ch ();
	lmsd_out_if out_ch ();

	led_matrix_scan_scroll_driver_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (in_ch),
		.result    (out_ch)
	);

	led_matrix_scan_scroll_driver_core_chk i_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (in_ch),
		.results   (out_ch),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result side back-pressure
	always @(posedge clk) begin
		out_ch.ready <= arst_n && (calm || $urandom_range(99) >= IDLE_PCT);
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[led_matrix_scan_scroll_driver_core] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic glyph_t random_glyph();
		glyph_t g;
		case ($urandom_range(3))
			0: g = glyph_t'({$urandom, $urandom});
			1: g = glyph_t'(1) << $urandom_range(GLYPH_W - 1);
			2: begin
				// random dots with whole rows blanked
				g = glyph_t'({$urandom, $urandom});
				for (int r = 0; r < ROWS; r++) begin
					if ($urandom_range(1)) begin
						for (int c = 0; c < COLS; c++) begin
							g[ROWS*c + r] = 1'b0;
						end
					end
				end
			end
			default: g = $urandom_range(1) ? FULL : '0;
		endcase
		return g;
	endfunction

	// One transfer on the item channel, after a random idle spell
	task automatic send_item(input logic [1:0] f, input glyph_t a, input glyph_t b,
			input logic sp, input logic [1:0] d, input gap_t g, input pos_t p);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid           <= 1'b1;
		in_ch.func            <= f;
		in_ch.glyph_a         <= a;
		in_ch.glyph_b         <= b;
		in_ch.glyph_is_space  <= sp;
		in_ch.scroll_dir      <= d;
		in_ch.gap_lines       <= g;
		in_ch.scroll_position <= p;
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
	endtask

	task automatic send_random(input logic [1:0] f, input glyph_t a, input logic sp);
		send_item(f, a, random_glyph(), sp, 2'($urandom), gap_t'($urandom), pos_t'($urandom));
	endtask

	// Let every expected result arrive, then give the pipeline time to settle
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(input logic [2:0] setting, input logic spare);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ROW_LEVEL;
		cfg_data  <= setting[2];
		@(posedge clk);
		cfg_index <= REG_COL_LEVEL;
		cfg_data  <= setting[1];
		@(posedge clk);
		cfg_index <= REG_ROTATE;
		cfg_data  <= setting[0];
		@(posedge clk);
		if (spare) begin
			// index with no register behind it
			cfg_index <= REG_SPARE;
			cfg_data  <= 1'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_step(inout int sent);
		int roll;
		int ticks;
		roll = $urandom_range(99);
		if (roll < 12) begin
			// space shown, then a run of ticks toward the blank freeze
			send_random(FUNC_SHOW, ($urandom_range(2) == 0) ? random_glyph() : '0, 1'b1);
			ticks = $urandom_range(6, 11);
			repeat (ticks) send_random(FUNC_TICK, random_glyph(), 1'($urandom));
			sent += ticks + 1;
		end else if (roll < 55) begin
			send_random(FUNC_TICK, random_glyph(), 1'($urandom));
			sent++;
		end else if (roll < 72) begin
			send_random(FUNC_SHOW, random_glyph(), $urandom_range(4) == 0);
			sent++;
		end else if (roll < 95) begin
			send_random(FUNC_SCROLL, random_glyph(), 1'($urandom));
			sent++;
		end else begin
			send_random(FUNC_NONE, random_glyph(), 1'($urandom));
		end
	endtask

	initial begin
		int sent;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = '0;
		cfg_data              = 1'b0;
		calm                  = 1'b0;
		in_ch.valid           = 1'b0;
		in_ch.func            = FUNC_TICK;
		in_ch.glyph_a         = '0;
		in_ch.glyph_b         = '0;
		in_ch.glyph_is_space  = 1'b0;
		in_ch.scroll_dir      = DIR_UP;
		in_ch.gap_lines       = '0;
		in_ch.scroll_position = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset register values
		send_item(FUNC_TICK, '0, '0, 1'b0, DIR_UP, '0, '0);
		send_item(FUNC_SHOW, FULL, FULL, 1'b0, DIR_LEFT, '1, '1);
		send_item(FUNC_TICK, '0, '0, 1'b0, DIR_UP, '0, '0);
		send_item(FUNC_SCROLL, CHECKER_A, FULL, 1'b0, DIR_UP, 3'd7, 4'd15);
		send_item(FUNC_TICK, '0, '0, 1'b0, DIR_UP, '0, '0);
		send_item(FUNC_SCROLL, CHECKER_A, CHECKER_B, 1'b0, DIR_DOWN, 3'd0, 4'd0);
		send_item(FUNC_TICK, '0, '0, 1'b0, DIR_UP, '0, '0);
		send_item(FUNC_SCROLL, CHECKER_A, FULL, 1'b0, DIR_RIGHT, 3'd0, 4'd15);
		send_item(FUNC_TICK, '0, '0, 1'b0, DIR_UP, '0, '0);
		send_item(FUNC_SCROLL, CHECKER_A, CHECKER_B, 1'b0, DIR_LEFT, 3'd2, 4'd3);
		send_item(FUNC_TICK, '0, '0, 1'b0, DIR_UP, '0, '0);
		send_item(FUNC_NONE, FULL, FULL, 1'b1, DIR_LEFT, '1, '1);
		send_item(FUNC_SHOW, '0, '0, 1'b1, DIR_UP, '0, '0);
		repeat (9) send_item(FUNC_TICK, '0, '0, 1'b0, DIR_UP, '0, '0);
		send_item(FUNC_SHOW, CHECKER_A, '0, 1'b0, DIR_UP, '0, '0);
		send_item(FUNC_TICK, '0, '0, 1'b0, DIR_UP, '0, '0);
		drain();

		// Random phases, each under its own register setting
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase < 4) begin
				set_config(PRESETS[phase], phase == 1);
			end else begin
				set_config(3'($urandom), 1'($urandom));
			end
			calm = (phase == 2);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				random_step(sent);
			end
			drain();
			calm = 1'b0;
		end

		#1;
		if (errors == 0 && pending == 0) begin
			$display("[led_matrix_scan_scroll_driver_core] OK");
		end else begin
			$display("[led_matrix_scan_scroll_driver_core] ERROR");
		end
		$finish;
	end

endmodule
